FILE: rtl/core/sn2d_pkg.sv
// Package for the 2D simplex noise unit: fixed-point constants, permutation ROM,
// gradient dot product and modulo-12 helpers, and the skew-to-corner beat type.
// No dependencies.
package sn2d_pkg;

  localparam int CoordWidthDef  = 16;
  localparam int OutFracBitsDef = 15;

  localparam logic [30:0] F2Q32   = 31'd1572067139;
  localparam logic [29:0] G2Q32   = 30'd907633386;
  localparam int          G2Q16   = 13849;
  localparam int          G2X2Q16 = 27699;
  localparam int          OneQ16  = 65536;
  localparam int          OfsLim  = 1048576;

  localparam int OFS_W  = 22;
  localparam int SQ_W   = 2 * OFS_W;
  localparam int DOT_W  = OFS_W + 1;
  localparam int T16_W  = 16;
  localparam int TERM_W = T16_W + 1 + DOT_W;
  localparam int ACC_W  = TERM_W + 10;

  typedef logic signed [OFS_W-1:0]  ofs_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic signed [TERM_W-1:0] term_t;

  typedef struct packed {
    logic       valid;
    ofs_t       ofs;
    logic [3:0] g0;
    logic [3:0] g1;
    logic [3:0] g2;
  } skew_beat_t;

  localparam logic [7:0] PermRom [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95, 8'd96,
    8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142,
    8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148, 8'd247,
    8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62, 8'd94, 8'd252, 8'd219, 8'd203,
    8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56,
    8'd87, 8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165,
    8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83,
    8'd111, 8'd229, 8'd122, 8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41,
    8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63,
    8'd161, 8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
    8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86, 8'd164,
    8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217, 8'd226, 8'd250,
    8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85,
    8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17, 8'd182, 8'd189,
    8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213, 8'd119, 8'd248, 8'd152, 8'd2, 8'd44,
    8'd154, 8'd163, 8'd70, 8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9,
    8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224,
    8'd232, 8'd178, 8'd185, 8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34,
    8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81,
    8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
    8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121, 8'd50,
    8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93, 8'd222, 8'd114,
    8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195, 8'd78, 8'd66, 8'd215,
    8'd61, 8'd156, 8'd180
  };

  // reciprocal of 12 scaled by 2^11, exact for 8-bit operands
  localparam logic [7:0] Mod12Recip = 8'd171;

  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [15:0] m;
    logic [7:0]  r;
    m = {8'd0, v} * {8'd0, Mod12Recip};
    r = v - 8'd12 * {3'd0, m[15:11]};
    return r[3:0];
  endfunction

  function automatic dot_t grad_dot(input logic [3:0] g, input ofs_t dx, input ofs_t dy);
    dot_t x;
    dot_t y;
    x = DOT_W'(dx);
    y = DOT_W'(dy);
    case (g)
      4'd0:    return x + y;
      4'd1:    return y - x;
      4'd2:    return x - y;
      4'd3:    return -x - y;
      4'd4:    return x;
      4'd5:    return -x;
      4'd6:    return x;
      4'd7:    return -x;
      4'd8:    return y;
      4'd9:    return -y;
      4'd10:   return y;
      4'd11:   return -y;
      default: return '0;
    endcase
  endfunction

endpackage

FILE: rtl/core/simplex_noise_2d_unit.sv
// 2D simplex noise unit: one coordinate pair per beat in, one Q1.OUT_FRAC_BITS value out.
// Pipeline: 4 skew/hash stages, 5 corner stages, sum-and-scale, round-and-saturate.
// Throughput one beat per cycle; a stall on the output freezes every stage together.
// Synchronous active-low reset clears the stage valid bits only; the data registers are not reset.
// Depends on sn2d_pkg, sn2d_skew and sn2d_corner.
module simplex_noise_2d_unit #(
  parameter int COORD_WIDTH   = sn2d_pkg::CoordWidthDef,
  parameter int OUT_FRAC_BITS = sn2d_pkg::OutFracBitsDef
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // x_coord, y_coord
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // noise_value
  output logic [((OUT_FRAC_BITS+1+7)/8)*8-1:0]    out_tdata
);
  import sn2d_pkg::*;

  localparam int OutW  = OUT_FRAC_BITS + 1;
  localparam int OutTW = ((OutW + 7) / 8) * 8;
  localparam int K     = 32 - OUT_FRAC_BITS;
  localparam int CornerLat = 5;
  localparam logic signed [ACC_W-1:0] SatHi = ACC_W'((longint'(1) <<< OUT_FRAC_BITS) - 1);
  localparam logic signed [ACC_W-1:0] SatLo = -SatHi - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] RndHalf = ACC_W'(longint'(1) <<< (K - 1));

  logic en;
  skew_beat_t skew_beat;
  ofs_t dx1, dy1, dxy2;
  term_t t0, t1, t2;
  logic [CornerLat-1:0] vp_r;
  logic vacc_r;
  logic signed [ACC_W-1:0] acc_r, rnd, sh, sat;
  logic out_tvalid_r;
  logic [OutW-1:0] out_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  sn2d_skew #(.COORD_WIDTH(COORD_WIDTH)) u_skew (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_x     ($signed(in_tdata[COORD_WIDTH-1:0])),
    .in_y     ($signed(in_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
    .beat_o   (skew_beat)
  );

  assign dx1  = skew_beat.ofs + OFS_W'(G2Q16);
  assign dy1  = skew_beat.ofs + OFS_W'(G2Q16 - OneQ16);
  assign dxy2 = skew_beat.ofs + OFS_W'(G2X2Q16 - OneQ16);

  sn2d_corner u_c0 (.clk(clk), .en(en), .dx_i(skew_beat.ofs), .dy_i(skew_beat.ofs),
                    .g_i(skew_beat.g0), .term_o(t0));
  sn2d_corner u_c1 (.clk(clk), .en(en), .dx_i(dx1), .dy_i(dy1), .g_i(skew_beat.g1),
                    .term_o(t1));
  sn2d_corner u_c2 (.clk(clk), .en(en), .dx_i(dxy2), .dy_i(dxy2), .g_i(skew_beat.g2),
                    .term_o(t2));

  assign rnd = acc_r + RndHalf;
  assign sh  = rnd >>> K;
  always_comb begin
    if (sh > SatHi) begin
      sat = SatHi;
    end else if (sh < SatLo) begin
      sat = SatLo;
    end else begin
      sat = sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r         <= '0;
      vacc_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      vp_r         <= {vp_r[CornerLat-2:0], skew_beat.valid};
      vacc_r       <= vp_r[CornerLat-1];
      out_tvalid_r <= vacc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= (ACC_W'(t0) + ACC_W'(t1) + ACC_W'(t2)) * ACC_W'(70);
      out_r <= sat[OutW-1:0];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OutTW'(out_r);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  a_stall_holds_valids: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(vp_r) && $stable(vacc_r))
    else $error("stage valid bits moved during stall");
  a_stall_holds_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (vacc_r && !in_tready) |=> $stable(acc_r) && vacc_r)
    else $error("accumulator beat lost during stall");

endmodule

FILE: rtl/core/sn2d_skew.sv
// Skew and hash front end: four stages from a coordinate pair to the corner
// offset and three gradient indices. Depends on sn2d_pkg.
module sn2d_skew #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  output sn2d_pkg::skew_beat_t          beat_o
);
  import sn2d_pkg::*;

  localparam int SumW = COORD_WIDTH + 1;
  localparam int PW   = SumW + 31;
  localparam int FsW  = COORD_WIDTH + 2;
  localparam int S2W  = COORD_WIDTH + 3;
  localparam int TW   = S2W + 31;
  localparam int QW   = COORD_WIDTH + 36;
  localparam logic signed [QW-1:0] LimHi = QW'(OfsLim);
  localparam logic signed [QW-1:0] LimLo = -QW'(OfsLim);

  logic v1_r, v2_r, v3_r, v4_r;

  logic signed [SumW-1:0] sum_nxt, sum1_r;
  logic [SumW-1:0]        mag;
  logic [PW-1:0]          p1_r;
  logic                   neg1_r;
  logic [7:0]             xl1_r, yl1_r;

  logic [PW:0]             pc;
  logic signed [FsW-1:0]   fs_nxt, fs2_r, fs3_r;
  logic signed [S2W-1:0]   sum2_r;
  logic [7:0]              ii2_r, jj2_r, jj1, ii3_r, pj0_r, pj1_r;

  logic signed [TW-1:0]    t3_r;
  logic signed [QW-1:0]    q, r16;
  logic [7:0]              a0, a1, a2;
  ofs_t                    ofs_nxt, ofs_r;
  logic [3:0]              g0_r, g1_r, g2_r;

  assign sum_nxt = SumW'(in_x) + SumW'(in_y);
  assign mag     = sum_nxt[SumW-1] ? SumW'(-sum_nxt) : SumW'(sum_nxt);

  assign pc     = {1'b0, p1_r} + (PW+1)'(32'hFFFF_FFFF);
  assign fs_nxt = neg1_r ? -$signed({1'b0, pc[PW:32]}) : $signed({2'b00, p1_r[PW-1:32]});

  assign jj1 = jj2_r + 8'd1;

  assign q   = ((-QW'(fs3_r)) <<< 32) + QW'(t3_r) + QW'(32768);
  assign r16 = q >>> 16;
  always_comb begin
    if (r16 > LimHi) begin
      ofs_nxt = OFS_W'(LimHi);
    end else if (r16 < LimLo) begin
      ofs_nxt = OFS_W'(LimLo);
    end else begin
      ofs_nxt = OFS_W'(r16);
    end
  end

  assign a0 = ii3_r + pj0_r;
  assign a1 = ii3_r + pj1_r;
  assign a2 = ii3_r + pj1_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= PW'(mag) * PW'(F2Q32);
      neg1_r <= sum_nxt[SumW-1];
      sum1_r <= sum_nxt;
      xl1_r  <= in_x[7:0];
      yl1_r  <= in_y[7:0];

      fs2_r  <= fs_nxt;
      sum2_r <= S2W'(sum1_r) + (S2W'(fs_nxt) <<< 1);
      ii2_r  <= xl1_r + fs_nxt[7:0];
      jj2_r  <= yl1_r + fs_nxt[7:0];

      t3_r   <= TW'(sum2_r) * TW'($signed({1'b0, G2Q32}));
      fs3_r  <= fs2_r;
      ii3_r  <= ii2_r;
      pj0_r  <= PermRom[jj2_r];
      pj1_r  <= PermRom[jj1];

      ofs_r <= ofs_nxt;
      g0_r  <= mod12(PermRom[a0]);
      g1_r  <= mod12(PermRom[a1]);
      g2_r  <= mod12(PermRom[a2]);
    end
  end

  // offsets on both axes are equal at integer points, so the middle corner is (0,1)
  always_comb begin
    beat_o.valid = v4_r;
    beat_o.ofs   = ofs_r;
    beat_o.g0    = g0_r;
    beat_o.g1    = g1_r;
    beat_o.g2    = g2_r;
  end

endmodule

FILE: rtl/core/sn2d_corner.sv
// One simplex corner: five stages of squared distance, falloff powers and
// gradient dot product into a Q.32 contribution. Depends on sn2d_pkg.
module sn2d_corner (
  input  logic            clk,
  input  logic            en,
  input  sn2d_pkg::ofs_t  dx_i,
  input  sn2d_pkg::ofs_t  dy_i,
  input  logic [3:0]      g_i,
  output sn2d_pkg::term_t term_o
);
  import sn2d_pkg::*;

  localparam logic signed [SQ_W+1:0] HalfQ32 = (SQ_W+2)'(64'sd2147483648);

  logic signed [SQ_W-1:0]   sqx_r, sqy_r;
  dot_t                     dot1_r, dot2_r, dot3_r, dot4_r;
  logic signed [SQ_W+1:0]   t_nxt;
  logic [T16_W-1:0]         t16_r, t2_r, t4_r;
  logic [2*T16_W-1:0]       p2, p4;
  term_t                    term_r;

  assign t_nxt = HalfQ32 - (SQ_W+2)'(sqx_r) - (SQ_W+2)'(sqy_r);
  assign p2    = t16_r * t16_r;
  assign p4    = t2_r * t2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r  <= dx_i * dx_i;
      sqy_r  <= dy_i * dy_i;
      dot1_r <= grad_dot(g_i, dx_i, dy_i);

      t16_r  <= t_nxt[SQ_W+1] ? '0 : t_nxt[31:16];
      dot2_r <= dot1_r;

      t2_r   <= p2[31:16];
      dot3_r <= dot2_r;

      t4_r   <= p4[31:16];
      dot4_r <= dot3_r;

      term_r <= TERM_W'($signed({1'b0, t4_r}) * dot4_r);
    end
  end

  assign term_o = term_r;

endmodule
